>>> sv/plpwo_pkg.sv
// Shared types and constants for the parallel LED pulse-width output block.
// Used by the channel interfaces, the pulse engine and the top level.
package plpwo_pkg;

  localparam int unsigned PinCount  = 16;
  localparam int unsigned PinWidth  = 16;
  localparam int unsigned TimeWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // Pins at or above PinCount never drive high.
  localparam logic [PinWidth-1:0] UsablePins =
      PinWidth'((64'(1) << PinCount) - 64'(1));

  localparam logic [TimeWidth-1:0] CountMax = '1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PIN_MASK   = 2'd0,
    REG_ZERO_HIGH  = 2'd1,
    REG_ONE_HIGH   = 2'd2,
    REG_BIT_PERIOD = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PinWidth-1:0]  pin_mask;
    logic [TimeWidth-1:0] zero_high_cycles;
    logic [TimeWidth-1:0] one_high_cycles;
    logic [TimeWidth-1:0] bit_period_cycles;
  } cfg_t;

  typedef struct packed {
    logic                slice_valid;
    logic [PinWidth-1:0] data_bits;
    logic [PinWidth-1:0] active_bits;
  } slice_t;

  typedef struct packed {
    logic [PinWidth-1:0] pin_levels;
    logic                slice_taken;
    logic                busy_res;
  } result_t;

endpackage

>>> sv/plpwo_if.sv
// Valid/ready channel interfaces: slice input, result output, register writes.
// Depends on plpwo_pkg.
interface plpwo_slice_if;
  logic                          valid;
  logic                          ready;
  logic                          slice_valid;
  logic [plpwo_pkg::PinWidth-1:0] data_bits;
  logic [plpwo_pkg::PinWidth-1:0] active_bits;

  modport source (output valid, slice_valid, data_bits, active_bits, input ready);
  modport sink   (input valid, slice_valid, data_bits, active_bits, output ready);
endinterface

interface plpwo_result_if;
  logic                          valid;
  logic                          ready;
  logic [plpwo_pkg::PinWidth-1:0] pin_levels;
  logic                          slice_taken;
  logic                          busy_res;

  modport source (output valid, pin_levels, slice_taken, busy_res, input ready);
  modport sink   (input valid, pin_levels, slice_taken, busy_res, output ready);
endinterface

interface plpwo_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [plpwo_pkg::CfgIdxWidth-1:0] index;
  logic [plpwo_pkg::TimeWidth-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

>>> sv/parallel_led_pulse_width_output.sv
// Top level of the parallel LED pulse-width output block.
// Depends on plpwo_pkg, the plpwo_*_if interfaces and plpwo_pulse.
//
// Usage:
//   slice_i  : one item per timer tick: slice_valid, data_bits, active_bits.
//   result_o : one item per input item: pin_levels, slice_taken, busy_res.
//   cfg_i    : register writes (pin mask, zero-high, one-high, bit period),
//              always ready; write only while the block is idle.
// Each item is captured in an input register, stepped through the pulse
// engine once the result register is free or being drained, and held in a
// result register. Throughput is one item per cycle while the receiver does
// not stall; the pulse engine step between the two registers is
// combinational.
// The input register accepts a new item while a result is waiting, as long
// as the result register can move on.
// Reset clears both registers, sets the timing registers to 63/127/199,
// the mask to zero and the period counter to expired, so the first offered
// slice is taken at once. When the receiver stalls, the result holds, the
// pulse engine stops and, once the input register is full, slice_i.ready
// drops; pulse timing advances only with accepted items.
module parallel_led_pulse_width_output (
  input  logic clk_i,
  input  logic rst_ni,
  plpwo_slice_if.sink    slice_i,
  plpwo_result_if.source result_o,
  plpwo_cfg_if.sink      cfg_i
);

  plpwo_pkg::cfg_t    cfg_q;
  plpwo_pkg::slice_t  in_q;
  logic               in_valid_q;
  plpwo_pkg::result_t res_d, res_q;
  logic               out_valid_q;
  logic               advance;

  // Step the held item when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || result_o.ready);
  assign slice_i.ready = !in_valid_q || advance;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_mask          <= '0;
      cfg_q.zero_high_cycles  <= plpwo_pkg::TimeWidth'(63);
      cfg_q.one_high_cycles   <= plpwo_pkg::TimeWidth'(127);
      cfg_q.bit_period_cycles <= plpwo_pkg::TimeWidth'(199);
    end else if (cfg_i.valid) begin
      case (plpwo_pkg::cfg_reg_e'(cfg_i.index))
        plpwo_pkg::REG_PIN_MASK:   cfg_q.pin_mask          <= cfg_i.wdata;
        plpwo_pkg::REG_ZERO_HIGH:  cfg_q.zero_high_cycles  <= cfg_i.wdata;
        plpwo_pkg::REG_ONE_HIGH:   cfg_q.one_high_cycles   <= cfg_i.wdata;
        plpwo_pkg::REG_BIT_PERIOD: cfg_q.bit_period_cycles <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (slice_i.ready) begin
      in_valid_q <= slice_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slice_i.valid && slice_i.ready) begin
      in_q.slice_valid <= slice_i.slice_valid;
      in_q.data_bits   <= slice_i.data_bits;
      in_q.active_bits <= slice_i.active_bits;
    end
  end

  plpwo_pulse u_pulse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg_q),
    .slice_i  (in_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.pin_levels  = res_q.pin_levels;
  assign result_o.slice_taken = res_q.slice_taken;
  assign result_o.busy_res    = res_q.busy_res;

  a_step_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("stepped item lost before result register");

  a_held_item_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q) else $error("held item dropped");

  a_no_step_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !advance)
    else $error("engine stepped while result stalled");

endmodule

>>> sv/plpwo_pulse.sv
// Pulse engine: period counter, pulse phase, zero-pin latch and pin register.
// One step per advanced item. Depends on plpwo_pkg.
module plpwo_pulse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  plpwo_pkg::cfg_t   cfg_i,
  input  plpwo_pkg::slice_t slice_i,
  output plpwo_pkg::result_t result_o
);

  logic [plpwo_pkg::TimeWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic                            phase_q, phase_d;
  logic [plpwo_pkg::PinWidth-1:0]  zero_q, zero_d;
  logic [plpwo_pkg::PinWidth-1:0]  pins_q, pins_d;
  logic [plpwo_pkg::PinWidth-1:0]  enabled;
  logic                            take;

  assign enabled = cfg_i.pin_mask & plpwo_pkg::UsablePins;
  assign cnt_inc = (cnt_q == plpwo_pkg::CountMax) ? cnt_q
                                                  : cnt_q + plpwo_pkg::TimeWidth'(1);
  assign take = slice_i.slice_valid && !phase_q && (cnt_inc >= cfg_i.bit_period_cycles);

  always_comb begin
    cnt_d   = cnt_inc;
    phase_d = phase_q;
    zero_d  = zero_q;
    pins_d  = pins_q;
    if (take) begin
      cnt_d   = '0;
      phase_d = 1'b1;
      pins_d  = pins_q | enabled;
      zero_d  = enabled & ~(slice_i.data_bits & slice_i.active_bits);
    end
    if (phase_d) begin
      // drop zero pins first, then everything at the end of the long pulse
      if (cnt_d >= cfg_i.zero_high_cycles) begin
        pins_d = pins_d & ~zero_d;
      end
      if (cnt_d >= cfg_i.one_high_cycles) begin
        pins_d  = '0;
        phase_d = 1'b0;
      end
    end
  end

  always_comb begin
    result_o.pin_levels  = pins_d;
    result_o.slice_taken = take;
    result_o.busy_res    = phase_d || (cnt_d < cfg_i.bit_period_cycles);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= plpwo_pkg::CountMax;
      phase_q <= 1'b0;
      zero_q  <= '0;
      pins_q  <= '0;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      zero_q  <= zero_d;
      pins_q  <= pins_d;
    end
  end

  a_no_take_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !take) else $error("slice taken while a pulse is high");

  a_pins_low_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q |-> (pins_q == '0)) else $error("pins high outside a pulse");

  a_take_restarts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && take) |=> (cnt_q == '0)) else $error("counter not cleared on rise");

endmodule

>>> test/plpwo_pulse_checker.sv
// Pulse timing predictor and result checker for parallel_led_pulse_width_output.
// Watches the slice, result and register write channels; depends on plpwo_pkg
// and the plpwo_*_if interfaces.
module plpwo_pulse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  plpwo_slice_if      slice_i,
  plpwo_result_if     result_i,
  plpwo_cfg_if        cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import plpwo_pkg::*;

  cfg_t                 regs;
  logic [TimeWidth-1:0] since_rise;
  logic                 high_phase;
  logic [PinWidth-1:0]  zero_pins;
  logic [PinWidth-1:0]  pin_state;

  result_t expected_levels_q[$];
  result_t want;
  slice_t  tick;

  // Advance the pulse timer by one tick and return the pin levels after it.
  function automatic result_t step_pulse_timer(input slice_t s);
    result_t             r;
    logic [PinWidth-1:0] enabled;
    r = '0;
    if (since_rise != CountMax) since_rise = since_rise + 1'b1;
    if (s.slice_valid && !high_phase && since_rise >= regs.bit_period_cycles) begin
      enabled       = regs.pin_mask & UsablePins;
      r.slice_taken = 1'b1;
      since_rise    = '0;
      pin_state     = pin_state | enabled;
      zero_pins     = enabled & ~(s.data_bits & s.active_bits);
      high_phase    = 1'b1;
    end
    if (high_phase) begin
      if (since_rise >= regs.zero_high_cycles) pin_state = pin_state & ~zero_pins;
      if (since_rise >= regs.one_high_cycles) begin
        pin_state  = '0;
        high_phase = 1'b0;
      end
    end
    r.pin_levels = pin_state;
    r.busy_res   = high_phase || (since_rise < regs.bit_period_cycles);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.pin_mask          = '0;
      regs.zero_high_cycles  = 16'd63;
      regs.one_high_cycles   = 16'd127;
      regs.bit_period_cycles = 16'd199;
      since_rise             = CountMax;
      high_phase             = 1'b0;
      zero_pins              = '0;
      pin_state              = '0;
      expected_levels_q.delete();
      fail_count_o           = 0;
      pending_o              = 0;
    end else begin
      // Compare first: a result never belongs to an item taken at the same edge.
      if (result_i.valid && result_i.ready) begin
        if (expected_levels_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected: pin_levels %h taken %b busy %b",
                   $time, result_i.pin_levels, result_i.slice_taken, result_i.busy_res);
        end else begin
          want = expected_levels_q.pop_front();
          if (result_i.pin_levels !== want.pin_levels) begin
            fail_count_o++;
            $display("%0t: pin_levels expected %h actual %h",
                     $time, want.pin_levels, result_i.pin_levels);
          end
          if (result_i.slice_taken !== want.slice_taken) begin
            fail_count_o++;
            $display("%0t: slice_taken expected %b actual %b",
                     $time, want.slice_taken, result_i.slice_taken);
          end
          if (result_i.busy_res !== want.busy_res) begin
            fail_count_o++;
            $display("%0t: busy_res expected %b actual %b",
                     $time, want.busy_res, result_i.busy_res);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_PIN_MASK:   regs.pin_mask          = cfg_i.wdata;
          REG_ZERO_HIGH:  regs.zero_high_cycles  = cfg_i.wdata;
          REG_ONE_HIGH:   regs.one_high_cycles   = cfg_i.wdata;
          REG_BIT_PERIOD: regs.bit_period_cycles = cfg_i.wdata;
          default: ;
        endcase
      end
      if (slice_i.valid && slice_i.ready) begin
        tick.slice_valid = slice_i.slice_valid;
        tick.data_bits   = slice_i.data_bits;
        tick.active_bits = slice_i.active_bits;
        expected_levels_q.push_back(step_pulse_timer(tick));
      end
      pending_o = expected_levels_q.size();
    end
  end

endmodule

>>> test/parallel_led_pulse_width_output_tb.sv
// Stimulus and verdict for parallel_led_pulse_width_output: directed pulse
// cases, then random tick streams over many timing settings and idle mixes.
// Depends on plpwo_pkg, the plpwo_*_if interfaces and plpwo_pulse_checker.
module parallel_led_pulse_width_output_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plpwo_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned TicksPerPhase = 160;

  logic clk_i;
  logic rst_ni;

  plpwo_slice_if  slice_if ();
  plpwo_result_if result_if ();
  plpwo_cfg_if    cfg_if ();

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  parallel_led_pulse_width_output uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slice_i  (slice_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  plpwo_pulse_checker u_pulse_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slice_i      (slice_if),
    .result_i     (result_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("parallel_led_pulse_width_output_tb failed");
      $finish;
    end
  end

  // Hold ready low through reset, then stall at the phase's rate.
  always @(posedge clk_i) begin
    result_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_slice(input logic v, input logic [PinWidth-1:0] data,
                            input logic [PinWidth-1:0] active);
    while ($urandom_range(99) < send_idle_pct) begin
      slice_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    slice_if.valid       <= 1'b1;
    slice_if.slice_valid <= v;
    slice_if.data_bits   <= data;
    slice_if.active_bits <= active;
    @(posedge clk_i);
    while (!slice_if.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [TimeWidth-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_PIN_MASK, c.pin_mask);
    write_reg(REG_ZERO_HIGH, c.zero_high_cycles);
    write_reg(REG_ONE_HIGH, c.one_high_cycles);
    write_reg(REG_BIT_PERIOD, c.bit_period_cycles);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering ticks and wait until every result is back.
  task automatic settle();
    slice_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [PinWidth-1:0] pick_pins();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return '1;
    if (roll == 1) return '0;
    return PinWidth'($urandom);
  endfunction

  initial begin
    cfg_t        c;
    int unsigned mode;

    slice_if.valid       = 1'b0;
    slice_if.slice_valid = 1'b0;
    slice_if.data_bits   = '0;
    slice_if.active_bits = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_PIN_MASK;
    cfg_if.wdata         = '0;
    rst_ni               = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the first slice is taken at once, mask still empty.
    send_slice(1'b1, '1, '1);
    send_slice(1'b1, '1, '1);
    send_slice(1'b0, '0, '0);

    // Zero high times and zero period: pins never show high, every slice taken.
    settle();
    c = '{pin_mask: '1, zero_high_cycles: '0, one_high_cycles: '0, bit_period_cycles: '0};
    load_config(c);
    send_slice(1'b1, '1, '1);
    send_slice(1'b1, '0, '0);
    send_slice(1'b1, 16'hA5A5, 16'h0F0F);

    // Period shorter than the one-high time, slices offered while busy.
    settle();
    c = '{pin_mask: '1, zero_high_cycles: 16'd1, one_high_cycles: 16'd3,
          bit_period_cycles: 16'd2};
    load_config(c);
    send_slice(1'b1, '1, 16'h00FF);
    send_slice(1'b1, '0, '1);
    send_slice(1'b1, '0, '1);
    send_slice(1'b1, 16'h5555, '1);
    send_slice(1'b1, '1, '1);
    send_slice(1'b0, '1, '1);
    send_slice(1'b0, '1, '1);
    send_slice(1'b1, '1, '0);

    // Zero-high time above one-high time, partial mask.
    settle();
    c = '{pin_mask: 16'h5A5A, zero_high_cycles: 16'd5, one_high_cycles: 16'd2,
          bit_period_cycles: 16'd3};
    load_config(c);
    send_slice(1'b1, 16'hFF00, '1);
    send_slice(1'b0, '0, '0);
    send_slice(1'b0, '0, '0);
    send_slice(1'b1, 16'h3C3C, 16'hF0F0);
    send_slice(1'b1, '1, '1);
    send_slice(1'b1, '0, '1);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      settle();
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 46 : (mode == 3) ? 9 : 0;
      recv_stall_pct = (mode == 2) ? 46 : (mode == 3) ? 9 : 0;
      if (p == 0) begin
        c = '{pin_mask: '1, zero_high_cycles: '1, one_high_cycles: '1,
              bit_period_cycles: '1};
      end else if (p == 1) begin
        c = '{pin_mask: '0, zero_high_cycles: '0, one_high_cycles: '0,
              bit_period_cycles: '0};
      end else if (p == 2) begin
        c = '{pin_mask: '1, zero_high_cycles: 16'd63, one_high_cycles: 16'd127,
              bit_period_cycles: 16'd199};
      end else begin
        c.pin_mask          = pick_pins();
        c.zero_high_cycles  = TimeWidth'($urandom_range(10));
        c.one_high_cycles   = TimeWidth'($urandom_range(12));
        c.bit_period_cycles = TimeWidth'($urandom_range(16));
      end
      load_config(c);
      repeat (TicksPerPhase) begin
        send_slice($urandom_range(99) < 60, pick_pins(), pick_pins());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("parallel_led_pulse_width_output_tb passed");
    end else begin
      $display("parallel_led_pulse_width_output_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/plpwo_pkg.sv
sv/plpwo_if.sv
sv/plpwo_pulse.sv
sv/parallel_led_pulse_width_output.sv
test/plpwo_pulse_checker.sv
test/parallel_led_pulse_width_output_tb.sv
